@@ src/rbf_pkg.sv @@
// Shared constants, kernel codes and the exponential table of the kernel row evaluator.
package rbf_pkg;

   localparam int MAX_CENTERS     = 64;
   localparam int COORD_FRAC_BITS = 16;
   localparam int IDX_W           = $clog2(MAX_CENTERS);
   localparam int NUM_W           = 7;
   localparam int COORD_W         = 20;
   localparam int INV_W           = 24;
   localparam int VALUE_W         = 32;

   localparam logic [2:0] KERNEL_LINEAR = 3'd1;
   localparam logic [2:0] KERNEL_TPS    = 3'd2;
   localparam logic [2:0] KERNEL_GAUSS  = 3'd3;
   localparam logic [2:0] KERNEL_MQ     = 3'd4;
   localparam logic [2:0] KERNEL_IMQ    = 3'd5;

   localparam logic [1:0] CSR_KERNEL_TYPE = 2'd0;
   localparam logic [1:0] CSR_INV_RADIUS  = 2'd1;
   localparam logic [1:0] CSR_NUM_CENTERS = 2'd2;

   localparam logic [16:0] LN2_Q16 = 17'd45426;

   // exp(-2^(i-16)) in Q0.30, rounded.
   function automatic logic [29:0] exp_factor(input logic [4:0] i);
      logic [29:0] e;
      unique case (i)
         5'd0:  e = 30'd1073725440;
         5'd1:  e = 30'd1073709056;
         5'd2:  e = 30'd1073676290;
         5'd3:  e = 30'd1073610760;
         5'd4:  e = 30'd1073479712;
         5'd5:  e = 30'd1073217664;
         5'd6:  e = 30'd1072693760;
         5'd7:  e = 30'd1071646719;
         5'd8:  e = 30'd1069555701;
         5'd9:  e = 30'd1065385899;
         5'd10: e = 30'd1057095000;
         5'd11: e = 30'd1040706261;
         5'd12: e = 30'd1008687096;
         5'd13: e = 30'd947573834;
         5'd14: e = 30'd836230973;
         5'd15: e = 30'd651257337;
         5'd16: e = 30'd395007542;
         5'd17: e = 30'd145315154;
         5'd18: e = 30'd19666268;
         5'd19: e = 30'd360200;
         5'd20: e = 30'd121;
         default: e = 30'd0;
      endcase
      return e;
   endfunction

endpackage

@@ src/rbf_kernel_row_eval_unit.sv @@
// Top level of the kernel row evaluator: center memory, sequencer and shared iterative units.
//
// Usage: the request channel (req_valid / req_stall) takes one word per item. A word with
// req_op 0 writes the center (req_coord_x, req_coord_y) into slot req_center_index of the
// center memory and produces nothing. A word with req_op 1 is a site: the block returns
// one response word per active center, in center order, carrying the kernel value in
// signed Q16.16, the center index and a last flag on the final center.
// Configuration (kernel type, inverse radius, number of centers) is written through the
// csr_ port, one register per cycle; the user must write it only while the block is idle;
// the block itself does not enforce this. A load does not stall the request channel.
// An evaluation works on one center at a time. Each center goes through distance and
// scaling, dominated by the 32-step square root, plus the kernel: linear uses r directly,
// the thin plate spline takes up to 30 normalize steps and 16 squaring steps, the Gaussian
// 21 steps, the multiquadric another 32-step root and the inverse multiquadric that root
// plus a 33-step divide. req_stall stays high while a site is being worked on.
// A finished word waits in the output register; the sequencer keeps computing the next
// center meanwhile and only holds when a second word is ready and rsp_stall is high.
// Reset clears the sequencer, the output valid and the configuration registers to kernel
// type linear, inverse radius 1.0 and one center; the center memory is not cleared.
module rbf_kernel_row_eval_unit
   import rbf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [IDX_W-1:0]           req_center_index,
   input  logic signed [COORD_W-1:0]  req_coord_x,
   input  logic signed [COORD_W-1:0]  req_coord_y,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_kernel_value,
   output logic [IDX_W-1:0]           rsp_center_id,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [INV_W-1:0]           csr_wdata
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RD    = 5'd1;
   localparam logic [4:0] S_DIFF  = 5'd2;
   localparam logic [4:0] S_SQ    = 5'd3;
   localparam logic [4:0] S_SUM   = 5'd4;
   localparam logic [4:0] S_SQRT  = 5'd5;
   localparam logic [4:0] S_SCALE = 5'd6;
   localparam logic [4:0] S_R     = 5'd7;
   localparam logic [4:0] S_KSEL  = 5'd8;
   localparam logic [4:0] S_TNORM = 5'd9;
   localparam logic [4:0] S_TSQ   = 5'd10;
   localparam logic [4:0] S_TLN   = 5'd11;
   localparam logic [4:0] S_TMUL  = 5'd12;
   localparam logic [4:0] S_TFIN  = 5'd13;
   localparam logic [4:0] S_GSQ   = 5'd14;
   localparam logic [4:0] S_GLOOP = 5'd15;
   localparam logic [4:0] S_GFIN  = 5'd16;
   localparam logic [4:0] S_MSQ   = 5'd17;
   localparam logic [4:0] S_MFIN  = 5'd18;
   localparam logic [4:0] S_DIV   = 5'd19;
   localparam logic [4:0] S_OUT   = 5'd20;

   localparam logic [63:0] R_CAP = 64'h7FFF_FFFF;

   // Configuration registers.
   logic [2:0]       ktype_ff;
   logic [INV_W-1:0] inv_ff;
   logic [NUM_W-1:0] num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ktype_ff <= KERNEL_LINEAR;
         inv_ff   <= INV_W'(65536);
         num_ff   <= NUM_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KERNEL_TYPE: ktype_ff <= csr_wdata[2:0];
            CSR_INV_RADIUS:  inv_ff   <= csr_wdata;
            CSR_NUM_CENTERS: num_ff   <= csr_wdata[NUM_W-1:0];
            default:         ;
         endcase
      end
   end

   // Center memory: one write port for loads, one registered read port for the sequencer.
   logic [2*COORD_W-1:0] mem [MAX_CENTERS];
   logic [2*COORD_W-1:0] rd_ff;
   logic [IDX_W-1:0]     ctr_ff;

   logic req_acc;
   assign req_acc   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_acc && !req_op) begin
         mem[req_center_index] <= {req_coord_x, req_coord_y};
      end
      rd_ff <= mem[ctr_ff];
   end

   // Number of active centers, limited to the store size.
   logic [NUM_W-1:0] n_eff;
   assign n_eff = (num_ff > NUM_W'(MAX_CENTERS)) ? NUM_W'(MAX_CENTERS) : num_ff;

   logic is_last;
   assign is_last = ((NUM_W'(ctr_ff) + NUM_W'(1)) == n_eff);

   logic [4:0] state_ff;
   logic       pass_ff;

   logic signed [COORD_W-1:0] sx_ff, sy_ff;
   logic signed [COORD_W:0]   dx_ff, dy_ff;
   logic [2*COORD_W+1:0]      sqx_ff, sqy_ff;

   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [5:0]  cnt_ff;
   logic [45:0] prod_ff;
   logic [30:0] r_ff;

   logic [30:0] lg_m_ff;
   logic [4:0]  lg_k_ff;
   logic [15:0] lg_frac_ff;
   logic signed [38:0] ln_prod_ff;
   logic [29:0] r2_ff;
   logic signed [53:0] tp_ff;

   logic [45:0] t_ff;
   logic [30:0] acc_ff;

   logic [32:0] rem_ff, dvd_ff, quo_ff;

   logic signed [VALUE_W-1:0] phi_ff;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [IDX_W-1:0]          rsp_id_ff;
   logic                      rsp_last_ff;

   // Combinational helpers: the multipliers, wide adds and shifts that the states use.
   logic signed [2*COORD_W+1:0] sqx_full, sqy_full;
   logic [63:0] sq_try;
   logic [61:0] r_sq;
   logic [61:0] lg_sq;
   logic [31:0] lg_m2;
   logic signed [5:0]  lg_int;
   logic signed [21:0] lg_val;
   logic signed [22:0] ln_val;
   logic [45:0] r23_sq;
   logic [60:0] g_prod;
   logic signed [37:0] tp_sh;
   logic [32:0] rem_sh;
   logic        out_free;

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign sq_try   = sq_res_ff + sq_bit_ff;
   assign r_sq     = {31'd0, r_ff} * {31'd0, r_ff};
   assign lg_sq    = {31'd0, lg_m_ff} * {31'd0, lg_m_ff};
   assign lg_m2    = lg_sq[61:30];
   assign lg_int   = $signed({1'b0, lg_k_ff}) - 6'sd16;
   assign lg_val   = {lg_int, lg_frac_ff};
   assign ln_val   = ln_prod_ff[38:16];
   assign r23_sq   = {23'd0, r_ff[22:0]} * {23'd0, r_ff[22:0]};
   assign g_prod   = {30'd0, acc_ff} * {31'd0, exp_factor(cnt_ff[4:0])};
   assign tp_sh    = tp_ff[53:16];
   assign rem_sh   = {rem_ff[31:0], dvd_ff[32]};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ctr_ff       <= '0;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
      end else begin
         // A new word enters the output register, or the one taken leaves it.
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc && req_op) begin
                  ctr_ff <= '0;
                  if (n_eff != '0) begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD:    state_ff <= S_DIFF;
            S_DIFF:  state_ff <= S_SQ;
            S_SQ:    state_ff <= S_SUM;
            S_SUM: begin
               pass_ff  <= 1'b0;
               cnt_ff   <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_ff <= pass_ff ? S_MFIN : S_SCALE;
               end
            end
            S_SCALE: state_ff <= S_R;
            S_R:     state_ff <= S_KSEL;
            S_KSEL: begin
               cnt_ff <= '0;
               unique case (ktype_ff)
                  KERNEL_TPS: begin
                     if (r_ff == '0 || r_ff[30:23] != '0) begin
                        state_ff <= S_OUT;
                     end else begin
                        state_ff <= S_TNORM;
                     end
                  end
                  KERNEL_GAUSS:          state_ff <= S_GSQ;
                  KERNEL_MQ, KERNEL_IMQ: state_ff <= S_MSQ;
                  default:               state_ff <= S_OUT;
               endcase
            end
            S_TNORM: begin
               if (lg_m_ff[30] || lg_k_ff == '0) begin
                  state_ff <= S_TSQ;
               end
            end
            S_TSQ: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd15) begin
                  state_ff <= S_TLN;
               end
            end
            S_TLN:  state_ff <= S_TMUL;
            S_TMUL: state_ff <= S_TFIN;
            S_TFIN: state_ff <= S_OUT;
            S_GSQ:  state_ff <= S_GLOOP;
            S_GLOOP: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd20) begin
                  state_ff <= S_GFIN;
               end
            end
            S_GFIN: state_ff <= S_OUT;
            S_MSQ: begin
               pass_ff  <= 1'b1;
               cnt_ff   <= '0;
               state_ff <= S_SQRT;
            end
            S_MFIN: begin
               cnt_ff   <= '0;
               state_ff <= (ktype_ff == KERNEL_MQ) ? S_OUT : S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd32) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  if (is_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ctr_ff   <= ctr_ff + IDX_W'(1);
                     state_ff <= S_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_acc && req_op) begin
         sx_ff <= req_coord_x;
         sy_ff <= req_coord_y;
      end
      unique case (state_ff)
         S_DIFF: begin
            dx_ff <= $signed({sx_ff[COORD_W-1], sx_ff})
                   - $signed({rd_ff[2*COORD_W-1], rd_ff[2*COORD_W-1:COORD_W]});
            dy_ff <= $signed({sy_ff[COORD_W-1], sy_ff})
                   - $signed({rd_ff[COORD_W-1], rd_ff[COORD_W-1:0]});
         end
         S_SQ: begin
            sqx_ff <= unsigned'(sqx_full);
            sqy_ff <= unsigned'(sqy_full);
         end
         S_SUM: begin
            sq_v_ff   <= 64'({1'b0, sqx_ff} + {1'b0, sqy_ff});
            sq_res_ff <= '0;
            sq_bit_ff <= 64'd1 << 62;
         end
         S_SQRT: begin
            // One step of the digit-by-digit square root.
            if (sq_v_ff >= sq_try) begin
               sq_v_ff   <= sq_v_ff - sq_try;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         S_SCALE: prod_ff <= sq_res_ff[21:0] * inv_ff;
         S_R:     r_ff    <= 31'(prod_ff >> COORD_FRAC_BITS);
         S_KSEL: begin
            lg_m_ff    <= r_ff;
            lg_k_ff    <= 5'd30;
            lg_frac_ff <= '0;
            acc_ff     <= 31'd1 << 30;
            unique case (ktype_ff)
               KERNEL_LINEAR: phi_ff <= $signed({1'b0, r_ff});
               KERNEL_TPS:    phi_ff <= (r_ff == '0) ? 32'sd0 : 32'sh7FFF_FFFF;
               default:       phi_ff <= 32'sd0;
            endcase
         end
         S_TNORM: begin
            if (!lg_m_ff[30] && lg_k_ff != '0) begin
               lg_m_ff <= lg_m_ff << 1;
               lg_k_ff <= lg_k_ff - 5'd1;
            end
         end
         S_TSQ: begin
            if (lg_m2[31]) begin
               lg_m_ff    <= lg_m2[31:1];
               lg_frac_ff <= {lg_frac_ff[14:0], 1'b1};
            end else begin
               lg_m_ff    <= lg_m2[30:0];
               lg_frac_ff <= {lg_frac_ff[14:0], 1'b0};
            end
         end
         S_TLN: begin
            ln_prod_ff <= lg_val * $signed(LN2_Q16);
            r2_ff      <= r23_sq[45:16];
         end
         S_TMUL: tp_ff <= $signed({1'b0, r2_ff}) * ln_val;
         S_TFIN: begin
            if (tp_sh > 38'sh0_7FFF_FFFF) begin
               phi_ff <= 32'sh7FFF_FFFF;
            end else if (tp_sh < -38'sh0_8000_0000) begin
               phi_ff <= 32'sh8000_0000;
            end else begin
               phi_ff <= tp_sh[31:0];
            end
         end
         S_GSQ: t_ff <= r_sq[61:16];
         S_GLOOP: begin
            if (t_ff[cnt_ff[4:0]]) begin
               acc_ff <= g_prod[60:30];
            end
         end
         S_GFIN: begin
            phi_ff <= (t_ff[45:21] != '0) ? 32'sd0 : $signed({15'd0, acc_ff[30:14]});
         end
         S_MSQ: begin
            sq_v_ff   <= {2'b00, r_sq} + (64'd1 << 32);
            sq_res_ff <= '0;
            sq_bit_ff <= 64'd1 << 62;
         end
         S_MFIN: begin
            phi_ff <= (sq_res_ff > R_CAP) ? 32'sh7FFF_FFFF : sq_res_ff[31:0];
            rem_ff <= '0;
            dvd_ff <= 33'd1 << 32;
            quo_ff <= '0;
         end
         S_DIV: begin
            // Restoring division of 2^32 by the root, one quotient bit per cycle.
            dvd_ff <= dvd_ff << 1;
            if (rem_sh >= {1'b0, sq_res_ff[31:0]}) begin
               rem_ff <= rem_sh - {1'b0, sq_res_ff[31:0]};
               quo_ff <= {quo_ff[31:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[31:0], 1'b0};
            end
            if (cnt_ff == 6'd32) begin
               phi_ff <= (rem_sh >= {1'b0, sq_res_ff[31:0]}) ? {quo_ff[30:0], 1'b1}
                                                              : {quo_ff[30:0], 1'b0};
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_value_ff <= phi_ff;
               rsp_id_ff    <= ctr_ff;
               rsp_last_ff  <= is_last;
            end
         end
         default: ;
      endcase
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;
   assign rsp_center_id    = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

@@ src/rbf_checker.sv @@
// Port-level assertions for the kernel row evaluator and their bind to the top level.
module rbf_checker
   import rbf_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_op,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [VALUE_W-1:0] rsp_kernel_value,
   input logic [IDX_W-1:0]          rsp_center_id,
   input logic                      rsp_last
);

   // A reset leaves no response word pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kernel_value)
                                    && $stable(rsp_center_id) && $stable(rsp_last)))
      else $error("stalled response word changed");

   // A center load does not leave the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_op) |=> !req_stall)
      else $error("block busy after a load");

   // While a word of a row other than the last one is pending, no new request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request accepted in the middle of a row");

endmodule

bind rbf_kernel_row_eval_unit rbf_checker u_rbf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kernel_value (rsp_kernel_value),
   .rsp_center_id    (rsp_center_id),
   .rsp_last         (rsp_last)
);
